FILE: hdl/bitmap_extent_coalescer_defines.svh
// Assertion macros shared by the bitmap extent coalescer modules.
`ifndef BITMAP_EXTENT_COALESCER_DEFINES_SVH
`define BITMAP_EXTENT_COALESCER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BEC_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define BEC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bec_pkg.sv
// Shared types and constants of the bitmap extent coalescer.
`default_nettype none

package bec_pkg;

    localparam int BYTE_W     = 62;
    localparam int OFFSET_W   = 48;
    localparam int FIRST_W    = 40;
    localparam int CBYTES_W   = 22;
    localparam int CLUSTERS_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CLUSTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINI_CLUSTERS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CLUSTERS = 3'd4;

    localparam logic [CBYTES_W-1:0]   RST_CLUSTER_BYTES  = 22'd4096;
    localparam logic [CLUSTERS_W-1:0] RST_MINI_CLUSTERS  = 16'd16;
    localparam logic [CLUSTERS_W-1:0] RST_BLOCK_CLUSTERS = 16'd2048;

    localparam logic KIND_EXTENT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int RES_SLOTS  = 4;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int CREDIT_W   = 5;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] extent_start;
        logic [BYTE_W-1:0] extent_length;
        logic [BYTE_W-1:0] total_bytes;
        logic              last_of_run;
    } t_result;

    typedef struct packed {
        logic [RES_SLOTS-1:0]          vld;
        t_result [RES_SLOTS-1:0]       res;
    } t_push;

    typedef struct packed {
        logic                nonempty;
        logic [CREDIT_W-1:0] count;
    } t_fifo_status;

endpackage

`default_nettype wire

FILE: hdl/bitmap_extent_coalescer.sv
// Top level: turns an allocation bitmap stream into byte extents and a summary.
//
//  Channel   Direction  Handshake                   Payload
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_wdata
//  bitmap    in         i_in_valid / o_in_stall     i_cluster_used, i_final_bit
//  result    out        o_out_valid / i_out_stall   o_kind, o_extent_start,
//                                                   o_extent_length, o_total_bytes,
//                                                   o_last_of_run
//
// One bitmap bit is accepted per cycle unless o_in_stall is high; its results pass through
// the decision, multiply-by-cluster-size and byte-sum stages on their way to the result queue.
// The 16-entry result queue delivers one result per cycle while i_out_stall is low, so an
// item that causes n results takes n queue entries and n pops to leave the output.
// The input stalls while fewer than four queue entries are free and unreserved.
// Reset is synchronous; there is no clearing pass.
`default_nettype none

module bitmap_extent_coalescer #(
    parameter int INDEX_BITS = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bec_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cluster_used,
    input  logic                             i_final_bit,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [bec_pkg::BYTE_W-1:0]       o_extent_start,
    output logic [bec_pkg::BYTE_W-1:0]       o_extent_length,
    output logic [bec_pkg::BYTE_W-1:0]       o_total_bytes,
    output logic                             o_last_of_run
);

    `include "bitmap_extent_coalescer_defines.svh"

    localparam int IB     = INDEX_BITS;
    localparam int BW     = bec_pkg::BYTE_W;
    localparam int CW     = bec_pkg::CREDIT_W;
    localparam int SIDX_W = ((IB > bec_pkg::FIRST_W) ? IB : bec_pkg::FIRST_W) + 1;
    localparam int CNT_W  = IB + 1;
    localparam int SP_W   = (SIDX_W + bec_pkg::CBYTES_W > BW) ? SIDX_W + bec_pkg::CBYTES_W : BW;
    localparam int LP_W   = (CNT_W + bec_pkg::CBYTES_W > BW) ? CNT_W + bec_pkg::CBYTES_W : BW;
    localparam int RES_VLD_W = bec_pkg::RES_SLOTS;
    localparam logic [CW:0] QUEUE_DEPTH = (CW + 1)'(bec_pkg::FIFO_DEPTH);

    logic [bec_pkg::OFFSET_W-1:0]   r_area_offset;
    logic [bec_pkg::FIRST_W-1:0]    r_first_cluster;
    logic [bec_pkg::CBYTES_W-1:0]   r_cluster_bytes;
    logic [bec_pkg::CLUSTERS_W-1:0] r_mini_clusters;
    logic [bec_pkg::CLUSTERS_W-1:0] r_block_clusters;

    logic [IB-1:0] r_pos;
    logic [IB-1:0] r_run_start;
    logic [IB-1:0] r_last_set;
    logic          r_run_open;
    logic [BW-1:0] r_byte_total;
    logic [CW-1:0] r_credit;

    logic [IB-1:0] n_pos;
    logic [IB-1:0] n_run_start;
    logic [IB-1:0] n_last_set;
    logic          n_run_open;
    logic [BW-1:0] n_byte_total;
    logic [CW-1:0] n_credit;

    logic              in_acc;
    logic              out_acc;
    logic [IB-1:0]     run_gap;
    logic              is_split;
    logic              is_close;
    logic              restart;
    logic [IB-1:0]     rs_after;
    logic [IB-1:0]     ls_after;
    logic              open_after;
    logic              flush;
    logic [IB-1:0]     run_rs;
    logic [IB-1:0]     close_span;
    logic [IB-1:0]     flush_span;
    logic [CNT_W-1:0]  close_cnt;
    logic [CNT_W-1:0]  flush_cnt;
    logic              scan_idle;

    logic              r_a_valid;
    logic              r_a_lead;
    logic              r_a_run_v;
    logic              r_a_tail;
    logic              r_a_wrap;
    logic              r_a_summ;
    logic [SIDX_W-1:0] r_a_sidx;
    logic [CNT_W-1:0]  r_a_cnt;
    logic [2:0]        a_nres;

    logic [SP_W-1:0]   sp_full;
    logic [LP_W-1:0]   lp_full;
    logic              r_b_valid;
    logic              r_b_lead;
    logic              r_b_run_v;
    logic              r_b_tail;
    logic              r_b_wrap;
    logic              r_b_summ;
    logic [BW-1:0]     r_b_sp;
    logic [BW-1:0]     r_b_lp;

    logic [BW-1:0]     off_ext;
    logic [BW-1:0]     cb_ext;
    logic [BW-1:0]     wrap_corr;
    logic [BW-1:0]     s_lr;
    logic              r_c_valid;
    logic              r_c_lead;
    logic              r_c_run_v;
    logic              r_c_tail;
    logic              r_c_summ;
    logic [BW-1:0]     r_c_run_start;
    logic [BW-1:0]     r_c_run_len;
    logic [BW-1:0]     r_c_tail_end;
    logic [BW-1:0]     r_c_s_lr;
    logic [BW-1:0]     r_c_s_all;

    logic [BW-1:0]     tot_lead;
    logic [BW-1:0]     tot_lr;
    logic [BW-1:0]     tot_all;
    logic [RES_VLD_W-1:0] vld;

    bec_pkg::t_push        push;
    bec_pkg::t_result      head;
    bec_pkg::t_fifo_status fifo_st;
    logic [CW:0]           occ_sum;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_offset    <= '0;
            r_first_cluster  <= '0;
            r_cluster_bytes  <= bec_pkg::RST_CLUSTER_BYTES;
            r_mini_clusters  <= bec_pkg::RST_MINI_CLUSTERS;
            r_block_clusters <= bec_pkg::RST_BLOCK_CLUSTERS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bec_pkg::CFG_AREA_OFFSET: begin
                    r_area_offset <= i_cfg_wdata[bec_pkg::OFFSET_W-1:0];
                end
                bec_pkg::CFG_FIRST_CLUSTER: begin
                    r_first_cluster <= i_cfg_wdata[bec_pkg::FIRST_W-1:0];
                end
                bec_pkg::CFG_CLUSTER_BYTES: begin
                    r_cluster_bytes <= i_cfg_wdata[bec_pkg::CBYTES_W-1:0];
                end
                bec_pkg::CFG_MINI_CLUSTERS: begin
                    r_mini_clusters <= i_cfg_wdata[bec_pkg::CLUSTERS_W-1:0];
                end
                bec_pkg::CFG_BLOCK_CLUSTERS: begin
                    r_block_clusters <= i_cfg_wdata[bec_pkg::CLUSTERS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = !i_rst_n || (r_credit < CW'(bec_pkg::RES_SLOTS));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;

    // Run tracking for the accepted bit.
    always_comb begin
        run_gap    = r_pos - r_run_start;
        is_split   = i_cluster_used && r_run_open && (run_gap == IB'(r_block_clusters));
        is_close   = !i_cluster_used && r_run_open && (run_gap >= IB'(r_mini_clusters));
        restart    = i_cluster_used && (!r_run_open || is_split);
        rs_after   = restart ? r_pos : r_run_start;
        ls_after   = i_cluster_used ? r_pos : r_last_set;
        open_after = i_cluster_used || (r_run_open && !is_close);
        flush      = i_final_bit && open_after;
        run_rs     = (is_split || is_close) ? r_run_start : rs_after;
        close_span = r_last_set - r_run_start;
        flush_span = ls_after - rs_after;
        close_cnt  = CNT_W'(close_span) + CNT_W'(1);
        flush_cnt  = CNT_W'(flush_span) + CNT_W'(1);
    end

    always_comb begin
        if (i_final_bit) begin
            n_pos       = '0;
            n_run_start = '0;
            n_last_set  = '0;
            n_run_open  = 1'b0;
        end else begin
            n_pos       = r_pos + IB'(1);
            n_run_start = rs_after;
            n_last_set  = ls_after;
            n_run_open  = open_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_run_start <= '0;
            r_last_set  <= '0;
            r_run_open  <= 1'b0;
        end else if (in_acc) begin
            r_pos       <= n_pos;
            r_run_start <= n_run_start;
            r_last_set  <= n_last_set;
            r_run_open  <= n_run_open;
        end
    end

    // Decision stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_lead  <= (r_pos == '0) && (r_area_offset != '0);
            r_a_run_v <= is_split || is_close || flush;
            r_a_tail  <= is_split && i_final_bit;
            r_a_wrap  <= r_pos < r_run_start;
            r_a_summ  <= i_final_bit;
            r_a_sidx  <= SIDX_W'(r_first_cluster) + SIDX_W'(run_rs);
            if (is_split) begin
                r_a_cnt <= CNT_W'(run_gap);
            end else if (is_close) begin
                r_a_cnt <= close_cnt;
            end else begin
                r_a_cnt <= flush_cnt;
            end
        end
    end

    assign a_nres = 3'($countones({r_a_lead, r_a_run_v, r_a_tail, r_a_summ}));

    // Multiply stage.
    assign sp_full = SP_W'(r_a_sidx) * SP_W'(r_cluster_bytes);
    assign lp_full = LP_W'(r_a_cnt) * LP_W'(r_cluster_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_lead  <= r_a_lead;
        r_b_run_v <= r_a_run_v;
        r_b_tail  <= r_a_tail;
        r_b_wrap  <= r_a_wrap;
        r_b_summ  <= r_a_summ;
        r_b_sp    <= sp_full[BW-1:0];
        r_b_lp    <= lp_full[BW-1:0];
    end

    // Byte offset stage.
    assign off_ext   = BW'(r_area_offset);
    assign cb_ext    = BW'(r_cluster_bytes);
    assign wrap_corr = r_b_wrap ? (cb_ext << IB) : '0;
    assign s_lr      = (r_b_lead ? off_ext : '0) + (r_b_run_v ? r_b_lp : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_lead      <= r_b_lead;
        r_c_run_v     <= r_b_run_v;
        r_c_tail      <= r_b_tail;
        r_c_summ      <= r_b_summ;
        r_c_run_start <= off_ext + r_b_sp;
        r_c_run_len   <= r_b_lp;
        r_c_tail_end  <= r_b_sp + r_b_lp - wrap_corr;
        r_c_s_lr      <= s_lr;
        r_c_s_all     <= s_lr + (r_b_tail ? cb_ext : '0);
    end

    // Running total and queue write.
    assign tot_lead = r_byte_total + off_ext;
    assign tot_lr   = r_byte_total + r_c_s_lr;
    assign tot_all  = r_byte_total + r_c_s_all;
    assign vld      = {r_c_summ, r_c_tail, r_c_run_v, r_c_lead} & {RES_VLD_W{r_c_valid}};

    always_comb begin
        push.vld = vld;

        push.res[0].kind          = bec_pkg::KIND_EXTENT;
        push.res[0].extent_start  = '0;
        push.res[0].extent_length = off_ext;
        push.res[0].total_bytes   = tot_lead;
        push.res[0].last_of_run   = vld[0] && (vld[3:1] == '0);

        push.res[1].kind          = bec_pkg::KIND_EXTENT;
        push.res[1].extent_start  = r_c_run_start;
        push.res[1].extent_length = r_c_run_len;
        push.res[1].total_bytes   = tot_lr;
        push.res[1].last_of_run   = vld[1] && (vld[3:2] == '0);

        push.res[2].kind          = bec_pkg::KIND_EXTENT;
        push.res[2].extent_start  = off_ext + r_c_tail_end;
        push.res[2].extent_length = cb_ext;
        push.res[2].total_bytes   = tot_all;
        push.res[2].last_of_run   = vld[2] && !vld[3];

        push.res[3].kind          = bec_pkg::KIND_SUMMARY;
        push.res[3].extent_start  = '0;
        push.res[3].extent_length = '0;
        push.res[3].total_bytes   = tot_all;
        push.res[3].last_of_run   = vld[3];
    end

    always_comb begin
        n_byte_total = r_byte_total;
        if (r_c_valid) begin
            n_byte_total = r_c_summ ? '0 : tot_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_total <= '0;
        end else begin
            r_byte_total <= n_byte_total;
        end
    end

    // Free queue entries not yet reserved by items in flight.
    assign n_credit = r_credit
                    - (in_acc ? CW'(bec_pkg::RES_SLOTS) : '0)
                    + (r_a_valid ? CW'(bec_pkg::RES_SLOTS) - CW'(a_nres) : '0)
                    + (out_acc ? CW'(1) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CW'(bec_pkg::FIFO_DEPTH);
        end else begin
            r_credit <= n_credit;
        end
    end

    bec_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_acc),
        .o_head   (head),
        .o_status (fifo_st)
    );

    assign o_out_valid     = fifo_st.nonempty;
    assign o_kind          = head.kind;
    assign o_extent_start  = head.extent_start;
    assign o_extent_length = head.extent_length;
    assign o_total_bytes   = head.total_bytes;
    assign o_last_of_run   = head.last_of_run;

    assign occ_sum   = (CW + 1)'(r_credit) + (CW + 1)'(fifo_st.count);
    assign scan_idle = (r_pos == '0) && !r_run_open && (r_run_start == '0);

    `BEC_CHECK(a_credit_bound, occ_sum <= QUEUE_DEPTH, "queue credit exceeds free space")
    `BEC_CHECK(a_tail_after_run, !(r_a_valid && r_a_tail) || r_a_run_v, "tail without split")
    `BEC_CHECK_NEXT(a_final_clears, in_acc && i_final_bit, scan_idle, "state kept after final bit")

endmodule

`default_nettype wire

FILE: hdl/bec_result_fifo.sv
// Result queue that takes up to four results per cycle and gives one per cycle while i_pop is high.
`default_nettype none

module bec_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bec_pkg::t_push       i_push,
    input  logic                 i_pop,
    output bec_pkg::t_result     o_head,
    output bec_pkg::t_fifo_status o_status
);

    `include "bitmap_extent_coalescer_defines.svh"

    bec_pkg::t_result r_mem [bec_pkg::FIFO_DEPTH];

    logic [bec_pkg::FIFO_AW-1:0]  r_wr;
    logic [bec_pkg::FIFO_AW-1:0]  n_wr;
    logic [bec_pkg::FIFO_AW-1:0]  r_rd;
    logic [bec_pkg::FIFO_AW-1:0]  n_rd;
    logic [bec_pkg::CREDIT_W-1:0] r_count;
    logic [bec_pkg::CREDIT_W-1:0] n_count;
    logic [bec_pkg::FIFO_AW-1:0]  slot_off [bec_pkg::RES_SLOTS];
    logic [bec_pkg::CREDIT_W-1:0] push_cnt;
    logic [bec_pkg::CREDIT_W:0]   fill_after;

    always_comb begin
        slot_off[0] = '0;
        for (int k = 1; k < bec_pkg::RES_SLOTS; k++) begin
            slot_off[k] = slot_off[k-1] + bec_pkg::FIFO_AW'(i_push.vld[k-1]);
        end
    end

    assign push_cnt   = bec_pkg::CREDIT_W'($countones(i_push.vld));
    assign n_wr       = r_wr + push_cnt[bec_pkg::FIFO_AW-1:0];
    assign n_rd       = i_pop ? r_rd + bec_pkg::FIFO_AW'(1) : r_rd;
    assign n_count    = r_count + push_cnt - (i_pop ? bec_pkg::CREDIT_W'(1) : '0);
    assign fill_after = (bec_pkg::CREDIT_W + 1)'(r_count) + (bec_pkg::CREDIT_W + 1)'(push_cnt);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bec_pkg::RES_SLOTS; k++) begin
            if (i_push.vld[k]) begin
                r_mem[r_wr + slot_off[k]] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head            = r_mem[r_rd];
    assign o_status.nonempty = (r_count != '0);
    assign o_status.count    = r_count;

    `BEC_CHECK(a_fifo_no_overflow, fill_after <= (bec_pkg::CREDIT_W + 1)'(bec_pkg::FIFO_DEPTH), "result queue overflow")
    `BEC_CHECK(a_fifo_no_underflow, !i_pop || (r_count != '0), "result queue underflow")
    `BEC_CHECK_NEXT(a_fifo_idle_holds, (i_push.vld == '0) && !i_pop, $stable(r_count) && $stable(r_rd), "idle queue changed")

endmodule

`default_nettype wire
